// File: rtl/slrx_pkg.sv
// shared types, codes and constants for the serial line flow handler
package slrx_pkg;

	// flow request and service codes
	typedef enum logic [2:0] {
		OP_SERVICE = 3'd0,
		OP_BLOCK   = 3'd1,
		OP_UNBLOCK = 3'd2,
		OP_FLUSH   = 3'd3,
		OP_START   = 3'd4,
		OP_SUSPEND = 3'd5,
		OP_RESUME  = 3'd6
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_INPUT_FLAGS = 2'd0,
		REG_START_CHAR  = 2'd1,
		REG_STOP_CHAR   = 2'd2,
		REG_PORT_OPEN   = 2'd3
	} reg_idx_t;

	// line status bit positions
	localparam int unsigned ST_RX    = 0;
	localparam int unsigned ST_TX    = 1;
	localparam int unsigned ST_NOCAR = 2;
	localparam int unsigned ST_FE    = 4;
	localparam int unsigned ST_OVR   = 5;
	localparam int unsigned ST_PE    = 6;

	// input flag bit positions
	localparam int unsigned IF_IXON   = 0;
	localparam int unsigned IF_IXANY  = 1;
	localparam int unsigned IF_INPCK  = 2;
	localparam int unsigned IF_IGNBRK = 3;
	localparam int unsigned IF_BRKINT = 4;
	localparam int unsigned IF_IGNPAR = 5;
	localparam int unsigned IF_PARMRK = 6;
	localparam int unsigned IF_ISTRIP = 7;

	// reset values of the registers
	localparam logic [7:0] INPUT_FLAGS_RST = 8'h00;
	localparam logic [6:0] START_CHAR_RST  = 7'd17;
	localparam logic [6:0] STOP_CHAR_RST   = 7'd19;

	localparam logic [7:0] MARK_BYTE = 8'hFF;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] line_status;
		logic [7:0] rx_data;
		logic       tx_pending;
		logic [7:0] tx_next;
	} item_t;

	typedef struct packed {
		logic [1:0] rx_count;
		logic [7:0] rx_first;
		logic [7:0] rx_second;
		logic [7:0] rx_third;
		logic       hangup;
		logic       break_signal;
		logic       flush_queues;
		logic       carrier_up;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_irq_on;
	} result_t;

	typedef struct packed {
		logic [7:0] input_flags;
		logic [6:0] start_char;
		logic [6:0] stop_char;
		logic       port_open;
	} cfg_t;

	typedef struct packed {
		logic carrier_on;
		logic output_stopped;
		logic input_blocked;
		logic xon_pending;
		logic xoff_pending;
		logic tx_irq_enabled;
	} line_state_t;

endpackage

// File: rtl/slrx_cfg.sv
// configuration register bank of the serial line flow handler
module slrx_cfg
	import slrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	logic [7:0] input_flags_q;
	logic [6:0] start_char_q;
	logic [6:0] stop_char_q;
	logic       port_open_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_flags_q <= INPUT_FLAGS_RST;
			start_char_q  <= START_CHAR_RST;
			stop_char_q   <= STOP_CHAR_RST;
			port_open_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INPUT_FLAGS: input_flags_q <= cfg_data;
				REG_START_CHAR:  start_char_q  <= cfg_data[6:0];
				REG_STOP_CHAR:   stop_char_q   <= cfg_data[6:0];
				REG_PORT_OPEN:   port_open_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.input_flags = input_flags_q;
	assign cfg.start_char  = start_char_q;
	assign cfg.stop_char   = stop_char_q;
	assign cfg.port_open   = port_open_q;

endmodule

// File: rtl/slrx_core.sv
// line state and single-pass service/flow logic of the serial line flow handler
module slrx_core
	import slrx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	line_state_t st_q;
	line_state_t ns;
	logic [7:0]  fl;
	logic [6:0]  ct;
	logic        skip;
	logic        err;

	// next state and result for one item
	always_comb begin
		ns   = st_q;
		res  = '0;
		fl   = cfg.input_flags;
		ct   = item.rx_data[6:0];
		skip = 1'b0;
		err  = item.line_status[ST_FE] | item.line_status[ST_OVR]
			| (item.line_status[ST_PE] & fl[IF_INPCK]);
		case (item.operation)
			OP_BLOCK: begin
				ns.xon_pending    = 1'b0;
				ns.input_blocked  = 1'b1;
				ns.xoff_pending   = 1'b1;
				ns.tx_irq_enabled = 1'b1;
			end
			OP_UNBLOCK: begin
				ns.xoff_pending   = 1'b0;
				ns.input_blocked  = 1'b0;
				ns.xon_pending    = 1'b1;
				ns.tx_irq_enabled = 1'b1;
			end
			OP_FLUSH: begin
				if (st_q.input_blocked) begin
					ns.xoff_pending   = 1'b0;
					ns.input_blocked  = 1'b0;
					ns.xon_pending    = 1'b1;
					ns.tx_irq_enabled = 1'b1;
				end
			end
			OP_START: begin
				if (!st_q.output_stopped && item.tx_pending)
					ns.tx_irq_enabled = 1'b1;
			end
			OP_SUSPEND: begin
				ns.output_stopped = 1'b1;
			end
			OP_RESUME: begin
				ns.output_stopped = 1'b0;
				if (item.tx_pending)
					ns.tx_irq_enabled = 1'b1;
			end
			OP_SERVICE: begin
				if (item.line_status[ST_NOCAR]) begin
					// carrier loss
					if (st_q.carrier_on && cfg.port_open) begin
						res.hangup       = 1'b1;
						res.flush_queues = 1'b1;
					end
					ns.carrier_on = 1'b0;
				end else begin
					if (!st_q.carrier_on) begin
						res.carrier_up = 1'b1;
						ns.carrier_on  = 1'b1;
					end
					// reception
					if (item.line_status[ST_RX]) begin
						if (fl[IF_IXON]) begin
							if (st_q.output_stopped) begin
								if (ct == cfg.start_char || fl[IF_IXANY]) begin
									ns.output_stopped = 1'b0;
									if (item.tx_pending)
										ns.tx_irq_enabled = 1'b1;
								end
							end else if (ct == cfg.stop_char) begin
								ns.output_stopped = 1'b1;
							end
							if (ct == cfg.start_char || ct == cfg.stop_char)
								skip = 1'b1;
						end
						if (!skip) begin
							if (err) begin
								if (item.rx_data == 8'h00) begin
									if (fl[IF_IGNBRK]) begin
										skip = 1'b1;
									end else if (fl[IF_BRKINT]) begin
										res.break_signal = 1'b1;
										res.flush_queues = 1'b1;
										skip = 1'b1;
									end
								end else if (fl[IF_IGNPAR]) begin
									skip = 1'b1;
								end
								if (!skip) begin
									if (fl[IF_PARMRK]) begin
										res.rx_first = MARK_BYTE;
										res.rx_third = item.rx_data;
										res.rx_count = 2'd3;
									end else begin
										res.rx_count = 2'd1;
									end
								end
							end else if (fl[IF_ISTRIP]) begin
								res.rx_first = {1'b0, ct};
								res.rx_count = 2'd1;
							end else if (item.rx_data == MARK_BYTE && fl[IF_PARMRK]) begin
								res.rx_first  = MARK_BYTE;
								res.rx_second = MARK_BYTE;
								res.rx_count  = 2'd2;
							end else begin
								res.rx_first = item.rx_data;
								res.rx_count = 2'd1;
							end
						end
					end
					// transmit slot: xon, then xoff, then host data
					if (ns.tx_irq_enabled && item.line_status[ST_TX]) begin
						if (ns.xon_pending) begin
							res.tx_valid   = 1'b1;
							res.tx_byte    = {1'b0, cfg.start_char};
							ns.xon_pending = 1'b0;
						end else if (ns.xoff_pending) begin
							res.tx_valid    = 1'b1;
							res.tx_byte     = {1'b0, cfg.stop_char};
							ns.xoff_pending = 1'b0;
						end else if (!ns.output_stopped && item.tx_pending) begin
							res.tx_valid = 1'b1;
							res.tx_byte  = item.tx_next;
						end else begin
							ns.tx_irq_enabled = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
		res.tx_irq_on = ns.tx_irq_enabled;
	end

	// line state update per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= ns;
		end
	end

endmodule

// File: rtl/serial_line_rx_tx_flow_handler_unit.sv
// top level of the serial line service and flow-control handler
//
// One item channel (item_valid/item_stall/item) carries either a line
// service event or a flow request; one result channel
// (result_valid/result_stall/result) returns exactly one result per item.
// Configuration registers are written over cfg_valid/cfg_ready with
// cfg_index and cfg_data; the user must write them only while no item is
// in flight, which the block itself does not enforce. An accepted item
// is held in an input register, processed by one pass of flag and
// byte-compare logic and stored in the result register, from which it is
// taken when result_stall is low. One item can be taken every cycle
// unless the receiver stalls; the single-pass service logic sets the rate.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; item_stall rises only when both
// stages are full. Reset clears both stages, the line state and the
// configuration registers to their defaults.
module serial_line_rx_tx_flow_handler_unit
	import slrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t core_res;
	logic    advance;

	slrx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slrx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance && valid_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	// stage handshake
	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_s2 <= core_res;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTH
	// input side stalls only with a full, stalled result stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item stalled without a stalled result");

	// a transmitted byte keeps the transmit interrupt on
	a_tx_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.tx_valid) |-> result.tx_irq_on)
		else $error("byte sent with transmit interrupt off");

	// flush comes only from hangup or break
	a_flush_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.flush_queues) |-> (result.hangup || result.break_signal))
		else $error("flush without hangup or break");

	// carrier loss and carrier gain never in one result
	a_carrier_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.hangup && result.carrier_up))
		else $error("hangup and carrier up together");

	// no reception or transmission on hangup
	a_hangup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.hangup) |-> (result.rx_count == 2'd0 && !result.tx_valid))
		else $error("data moved on hangup");
`endif

endmodule
